FILE: design/lpg_pkg.sv
// Package for the line pixel generator: shared command codes.
// No dependencies; used by line_pixel_generator.sv through scoped names.
package lpg_pkg;

    // Meaning of the one-bit kind that travels with each input transfer.
    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

endpackage

FILE: design/line_pixel_generator.sv
// Top level of the line pixel generator, a Bresenham line rasterizer.
// Depends on lpg_pkg (command codes).
//
//  Channel | Direction | tdata fields, low bit first            | tuser / tlast
//  --------+-----------+----------------------------------------+-----------------
//  s_      | in        | start_x, start_y, end_x, end_y, pen_in | tuser = cmd
//  m_      | out       | pixel_x, pixel_y, pixel_pen            | tlast = last
//
// On each accepted transfer the line state registers feed short add and
// compare logic whose result is written back to the state and, for a step,
// into the output stage. Throughput is one transfer per clock while s_tready
// is high. A two-entry output stage (output register plus skid register) keeps
// s_tready high while the skid register is empty, so a stall on the master
// side drops s_tready only once both entries are full. Reset is synchronous on
// aresetn low and leaves the block idle with both output entries empty.
module line_pixel_generator #(
    parameter int COORD_WIDTH = 16,
    localparam int S_DATA_W = ((4 * COORD_WIDTH + 8 + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * COORD_WIDTH + 8 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Input transfers.
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_x, start_y, end_x, end_y (each COORD_WIDTH, signed), pen_in (8),
    // then zero fill.
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd (1): start or step.
    input  logic [0:0]          s_tuser,
    // Result transfers.
    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_x, pixel_y (each COORD_WIDTH, signed), pixel_pen (8), then zero fill.
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 2;   // error term width
    localparam int PAD = M_DATA_W - (2 * CW + 8);

    // Input fields.
    logic signed [CW-1:0] in_start_x;
    logic signed [CW-1:0] in_start_y;
    logic signed [CW-1:0] in_end_x;
    logic signed [CW-1:0] in_end_y;
    logic [7:0]           in_pen;

    assign in_start_x = s_tdata[CW-1:0];
    assign in_start_y = s_tdata[2*CW-1:CW];
    assign in_end_x   = s_tdata[3*CW-1:2*CW];
    assign in_end_y   = s_tdata[4*CW-1:3*CW];
    assign in_pen     = s_tdata[4*CW+7:4*CW];

    // Line state.
    logic                 busy_reg, busy_next;
    logic signed [CW-1:0] cur_x_reg, cur_x_next;
    logic signed [CW-1:0] cur_y_reg, cur_y_next;
    logic signed [CW-1:0] target_x_reg, target_x_next;
    logic signed [CW-1:0] target_y_reg, target_y_next;
    logic [CW-1:0]        delta_x_reg, delta_x_next;
    logic [CW-1:0]        delta_y_reg, delta_y_next;
    logic                 x_dir_neg_reg, x_dir_neg_next;
    logic                 y_dir_neg_reg, y_dir_neg_next;
    logic signed [EW-1:0] error_term_reg, error_term_next;
    logic [7:0]           line_pen_reg, line_pen_next;

    // Output stage.
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [M_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic                skid_last_reg, skid_last_next;

    logic in_fire;
    logic is_step;
    logic emit;
    logic out_fire;
    logic at_end;

    assign s_tready = ~skid_valid_reg;
    assign in_fire  = s_tvalid & s_tready;
    assign is_step  = (s_tuser == lpg_pkg::CMD_STEP);
    assign emit     = in_fire & is_step & busy_reg;
    assign out_fire = out_valid_reg & m_tready;
    assign at_end   = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);

    // Start: spans, directions and the initial error term.
    logic signed [CW:0]   diff_x, diff_y;
    logic [CW:0]          abs_x, abs_y;
    logic signed [EW-1:0] err_start;

    always_comb begin
        diff_x    = $signed({in_end_x[CW-1], in_end_x})
                  - $signed({in_start_x[CW-1], in_start_x});
        diff_y    = $signed({in_end_y[CW-1], in_end_y})
                  - $signed({in_start_y[CW-1], in_start_y});
        abs_x     = diff_x[CW] ? (~diff_x + 1'b1) : diff_x;
        abs_y     = diff_y[CW] ? (~diff_y + 1'b1) : diff_y;
        err_start = $signed({2'b00, abs_x[CW-1:0]}) - $signed({2'b00, abs_y[CW-1:0]});
    end

    // Step: one Bresenham move. Doubling the error needs one extra bit.
    logic signed [EW:0] e2, err_wide, dx_ext, dy_ext, neg_dy, err_sum;
    logic               move_x, move_y;

    always_comb begin
        e2       = $signed({error_term_reg, 1'b0});
        err_wide = $signed({error_term_reg[EW-1], error_term_reg});
        dx_ext   = $signed({3'b000, delta_x_reg});
        dy_ext   = $signed({3'b000, delta_y_reg});
        neg_dy   = -dy_ext;
        move_x   = e2 > neg_dy;
        move_y   = e2 < dx_ext;
        err_sum  = err_wide - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);
    end

    always_comb begin
        busy_next       = busy_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        x_dir_neg_next  = x_dir_neg_reg;
        y_dir_neg_next  = y_dir_neg_reg;
        error_term_next = error_term_reg;
        line_pen_next   = line_pen_reg;
        if (in_fire && !is_step) begin
            // A start replaces whatever line is in progress.
            busy_next       = 1'b1;
            cur_x_next      = in_start_x;
            cur_y_next      = in_start_y;
            target_x_next   = in_end_x;
            target_y_next   = in_end_y;
            delta_x_next    = abs_x[CW-1:0];
            delta_y_next    = abs_y[CW-1:0];
            x_dir_neg_next  = diff_x[CW] || (diff_x == '0);
            y_dir_neg_next  = diff_y[CW] || (diff_y == '0);
            error_term_next = err_start;
            line_pen_next   = in_pen;
        end else if (emit) begin
            if (at_end) begin
                busy_next = 1'b0;
            end else begin
                error_term_next = err_sum[EW-1:0];
                if (move_x) begin
                    cur_x_next = cur_x_reg + (x_dir_neg_reg ? {CW{1'b1}} : CW'(1));
                end
                if (move_y) begin
                    cur_y_next = cur_y_reg + (y_dir_neg_reg ? {CW{1'b1}} : CW'(1));
                end
            end
        end
    end

    // Output stage: a new pixel goes to the output register when it is free or
    // being taken, otherwise into the skid register.
    logic [M_DATA_W-1:0] pixel_word;

    assign pixel_word = {{PAD{1'b0}}, line_pen_reg, cur_y_reg, cur_x_reg};

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_last_next  = skid_last_reg;
        if (out_fire || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end else if (emit) begin
                out_valid_next = 1'b1;
                out_data_next  = pixel_word;
                out_last_next  = at_end;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (emit) begin
            skid_valid_next = 1'b1;
            skid_data_next  = pixel_word;
            skid_last_next  = at_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        target_x_reg   <= target_x_next;
        target_y_reg   <= target_y_next;
        delta_x_reg    <= delta_x_next;
        delta_y_reg    <= delta_y_next;
        x_dir_neg_reg  <= x_dir_neg_next;
        y_dir_neg_reg  <= y_dir_neg_next;
        error_term_reg <= error_term_next;
        line_pen_reg   <= line_pen_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        skid_data_reg  <= skid_data_next;
        skid_last_reg  <= skid_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // The skid entry only fills behind a waiting output entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a pixel while the output entry is empty");

    // Emitting the end point finishes the line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && at_end |=> !busy_reg)
        else $error("line still busy after its end point was emitted");

    // A pixel marked last is always the line's end point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (skid_valid_reg ? skid_last_reg : out_last_reg) == $past(at_end))
        else $error("last flag does not match the end point test");
`endif

endmodule
